// File: rtl/dds_pkg.sv
// ----------------------------------------------------------------------------
// dds_pkg
// shared widths, limits and status types for the digit sorting unit
// ----------------------------------------------------------------------------
package dds_pkg;

    // input number and result digit widths
    localparam int NUMBER_W   = 30;
    localparam int DIGIT_W    = 4;

    // largest number of decimal digits accepted
    localparam int MAX_DIGITS = 9;
    localparam int RADIX      = 10;

    // bcd digits needed to hold any number of NUMBER_W bits
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;

    // digit count and conversion step counter widths
    localparam int COUNT_W    = $clog2(BCD_DIGITS + 1);
    localparam int CONV_CNT_W = $clog2(NUMBER_W + 1);

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(RADIX - 1);

    // radix to the power n, worked out at elaboration
    function automatic logic [63:0] radix_pow(input int n);
        logic [63:0] lim;
        lim = 64'd1;
        for (int i = 0; i < n && i < 19; i++) begin
            lim = lim * 64'(RADIX);
        end
        return lim;
    endfunction

    // first number that has too many digits
    localparam logic [63:0] UPPER_LIMIT = radix_pow(MAX_DIGITS);

    // status of the binary to bcd converter
    typedef struct packed {
        logic busy;
        logic done;
    } dds_conv_stat_t;

endpackage

// File: rtl/dds_bin2bcd.sv
// ----------------------------------------------------------------------------
// dds_bin2bcd
// bit-serial binary to bcd converter (shift and add three)
// ----------------------------------------------------------------------------
module dds_bin2bcd
    import dds_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUMBER_W-1:0]  number,
    output dds_conv_stat_t       stat,
    output logic [BCD_W-1:0]     bcd
);

    logic [NUMBER_W-1:0]   bin_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_adj;
    logic [CONV_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CONV_CNT_W'(NUMBER_W);
            bin_reg  <= number;
            bcd_reg  <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - CONV_CNT_W'(1);
                bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[NUMBER_W-1]};
                bin_reg <= {bin_reg[NUMBER_W-2:0], 1'b0};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == '0);
    assign bcd       = bcd_reg;

endmodule

// File: rtl/dds_sorter.sv
// ----------------------------------------------------------------------------
// dds_sorter
// digit histogram, then descending emission through an output register
// ----------------------------------------------------------------------------
module dds_sorter
    import dds_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  logic [BCD_W-1:0]    bcd,
    output logic                busy,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [DIGIT_W-1:0]  m_digit,
    output logic                m_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]          state_reg;
    logic [BCD_W-1:0]    digits_reg;
    logic [COUNT_W-1:0]  tally_reg [0:RADIX-1];
    logic [COUNT_W-1:0]  total_reg;
    logic [DIGIT_W-1:0]  sel_reg;
    logic                m_valid_reg;
    logic [DIGIT_W-1:0]  m_digit_reg;
    logic                m_last_reg;

    logic [DIGIT_W-1:0]  low_digit;
    logic [COUNT_W-1:0]  sel_tally;
    logic                out_free;
    logic                emit_fire;

    assign low_digit = digits_reg[DIGIT_W-1:0];
    assign sel_tally = tally_reg[sel_reg];
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_fire = (state_reg == ST_EMIT) && (sel_tally != '0) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (load) begin
                        state_reg  <= ST_COUNT;
                        digits_reg <= bcd;
                        total_reg  <= '0;
                        for (int i = 0; i < RADIX; i++) begin
                            tally_reg[i] <= '0;
                        end
                    end
                end
                ST_COUNT: begin
                    // one digit a cycle, lowest first, until only leading zeros remain
                    if (digits_reg == '0) begin
                        state_reg <= ST_EMIT;
                        sel_reg   <= DIGIT_MAX;
                    end else begin
                        for (int i = 0; i < RADIX; i++) begin
                            if (low_digit == DIGIT_W'(i)) begin
                                tally_reg[i] <= tally_reg[i] + COUNT_W'(1);
                            end
                        end
                        digits_reg <= digits_reg >> DIGIT_W;
                        total_reg  <= total_reg + COUNT_W'(1);
                    end
                end
                ST_EMIT: begin
                    if (sel_tally == '0) begin
                        sel_reg <= sel_reg - DIGIT_W'(1);
                    end else if (out_free) begin
                        m_digit_reg <= sel_reg;
                        m_last_reg  <= (total_reg == COUNT_W'(1));
                        total_reg   <= total_reg - COUNT_W'(1);
                        for (int i = 0; i < RADIX; i++) begin
                            if (sel_reg == DIGIT_W'(i)) begin
                                tally_reg[i] <= tally_reg[i] - COUNT_W'(1);
                            end
                        end
                        if (total_reg == COUNT_W'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy    = (state_reg != ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_digit = m_digit_reg;
    assign m_last  = m_last_reg;

endmodule

// File: rtl/decimal_digits_sorted_descending_unit.sv
// ----------------------------------------------------------------------------
// decimal_digits_sorted_descending_unit
// splits a number into decimal digits and streams them largest first
// ----------------------------------------------------------------------------
// channel  | direction | ports                       | meaning
// ---------+-----------+-----------------------------+--------------------------
// s_       | in        | s_valid s_ready s_number    | one number per request
// m_       | out       | m_valid m_ready m_digit/last| one digit per request
//
// a number in range is accepted, converted to bcd bit-serially, then
// its histogram is built one significant digit per cycle, then its digits
// are emitted largest first, each empty digit value skipped in a step of
// its own; zero or too many digits is dropped in the accept cycle.
// reset is synchronous, active low, and clears only control state.
// the final digit waits in the output register while the next number is
// taken; a stalled output holds the sorter in its emit phase.
// ----------------------------------------------------------------------------
module decimal_digits_sorted_descending_unit
    import dds_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [NUMBER_W-1:0] s_number,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [DIGIT_W-1:0]  m_digit,
    output logic                m_last
);

    dds_conv_stat_t      conv_stat;
    logic [BCD_W-1:0]    conv_bcd;
    logic                sort_busy;
    logic                in_range;
    logic                start;

    // zero and numbers with too many digits give no results
    assign in_range = (s_number != '0) && (64'(s_number) < UPPER_LIMIT);

    // one number in flight; conversion busy covers the hand-over cycle
    assign s_ready = !conv_stat.busy && !sort_busy;
    assign start   = s_valid && s_ready && in_range;

    // binary to bcd, one input bit a cycle
    dds_bin2bcd u_bin2bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .number  (s_number),
        .stat    (conv_stat),
        .bcd     (conv_bcd)
    );

    // histogram of digits, then emission from nine down to zero
    dds_sorter u_sorter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (conv_stat.done),
        .bcd     (conv_bcd),
        .busy    (sort_busy),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_digit (m_digit),
        .m_last  (m_last)
    );

endmodule

// File: sim/decimal_digits_sorted_descending_unit_test.sv
// ----------------------------------------------------------------------------
// decimal_digits_sorted_descending_unit_test
// drives numbers into the digit sorter and checks every streamed digit
// against a model that counts decimal digits and emits them largest first
// ----------------------------------------------------------------------------
module decimal_digits_sorted_descending_unit_test;
    import dds_pkg::*;

    // one expected digit request on the output channel
    typedef struct {
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } digit_rec_t;

    // holds the digits still due and checks each one as it leaves the block
    class digit_sort_scoreboard;
        digit_rec_t      digits_due[$];
        longint unsigned number_limit;
        int              errors;
        int              numbers_taken;
        int              numbers_dropped;
        int              digits_checked;

        function new();
            number_limit = 1;
            repeat (MAX_DIGITS) number_limit = number_limit * 10;
            errors          = 0;
            numbers_taken   = 0;
            numbers_dropped = 0;
            digits_checked  = 0;
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // tally the digits, then queue them from nine down to zero
        function void note_number(input logic [NUMBER_W-1:0] number);
            longint unsigned value;
            int              tally[10];
            int              total;
            int              sent;
            digit_rec_t      rec;
            value = 64'(number);
            numbers_taken++;
            if (value == 0 || value >= number_limit) begin
                numbers_dropped++;
                return;
            end
            foreach (tally[d]) tally[d] = 0;
            total = 0;
            while (value != 0) begin
                tally[value % 10]++;
                value = value / 10;
                total++;
            end
            sent = 0;
            for (int d = 9; d >= 0; d--) begin
                for (int k = 0; k < tally[d]; k++) begin
                    sent++;
                    rec.digit = DIGIT_W'(d);
                    rec.last  = (sent == total);
                    digits_due.push_back(rec);
                end
            end
        endfunction

        task check_digit(input logic [DIGIT_W-1:0] digit, input logic last);
            digit_rec_t want;
            if (digits_due.size() == 0) begin
                report($sformatf("digit %0d last %0b with nothing due", digit, last));
                return;
            end
            want = digits_due.pop_front();
            digits_checked++;
            if (digit !== want.digit)
                report($sformatf("digit %0d, wanted %0d", digit, want.digit));
            if (last !== want.last)
                report($sformatf("last %0b on digit %0d, wanted %0b", last, digit, want.last));
        endtask

        function int pending();
            return digits_due.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_valid  = 1'b0;
    logic                s_ready;
    logic [NUMBER_W-1:0] s_number = '0;
    logic                m_valid;
    logic                m_ready  = 1'b0;
    logic [DIGIT_W-1:0]  m_digit;
    logic                m_last;

    digit_sort_scoreboard sb = new();

    // idle percentages for the two sides, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int in_range_sent  = 0;

    decimal_digits_sorted_descending_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_number (s_number),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_digit  (m_digit),
        .m_last   (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // generous cap on the whole run
    initial begin
        #8000000;
        $display("simulation failed");
        $finish;
    end

    // receiver back-pressure, redrawn every falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // accepted requests on either channel go to the scoreboard
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_number(s_number);
        if (aresetn && m_valid && m_ready) sb.check_digit(m_digit, m_last);
    end

    // one number request; valid stays up across back-to-back requests
    task send_number(input logic [NUMBER_W-1:0] number);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid  <= 1'b0;
            s_number <= NUMBER_W'($urandom);
        end
        @(negedge aclk);
        s_valid  <= 1'b1;
        s_number <= number;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (number != 0 && longint'(number) < sb.number_limit) in_range_sent++;
    endtask

    // well-formed number with 1..9 digits, often drawn from a few digit values
    function automatic logic [NUMBER_W-1:0] random_in_range();
        int              ndig;
        int              lo;
        int              hi;
        int              d;
        longint unsigned value;
        ndig = ($urandom_range(7) == 0) ? MAX_DIGITS : $urandom_range(1, MAX_DIGITS);
        lo   = 0;
        hi   = 9;
        // narrow digit range now and then so values repeat a lot
        if ($urandom_range(2) == 0) begin
            lo = $urandom_range(9);
            hi = (lo + $urandom_range(2) > 9) ? 9 : lo + $urandom_range(2);
        end
        value = 0;
        for (int i = 0; i < ndig; i++) begin
            d = $urandom_range(hi, lo);
            if (i == 0 && d == 0) d = $urandom_range(9, 1);
            value = value * 10 + d;
        end
        return NUMBER_W'(value);
    endfunction

    // numbers the block must drop: zero or ten digits
    function automatic logic [NUMBER_W-1:0] random_out_of_range();
        case ($urandom_range(3))
            0:       return '0;
            1:       return NUMBER_W'(sb.number_limit);
            default: return NUMBER_W'($urandom_range(2 ** NUMBER_W - 1, sb.number_limit));
        endcase
    endfunction

    task run_random(input int target);
        while (in_range_sent < target) begin
            if ($urandom_range(99) < 12) send_number(random_out_of_range());
            else send_number(random_in_range());
        end
    endtask

    initial begin
        int unsigned directed[$];
        directed = '{
            0, 1, 9, 10, 42, 101, 24680, 13579, 70707,
            100000000, 500000000, 999999998, 999999999,
            1000000000, 1000000001, 2 ** NUMBER_W - 1, 2 ** (NUMBER_W - 1),
            123456789, 987654321, 111111111, 555555555, 102030405, 900000009
        };

        // reset held, then released on a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed corners with no idling on either side
        foreach (directed[i]) send_number(NUMBER_W'(directed[i]));

        // sender idles lightly, receiver stalls heavily
        send_idle_pct  = 14;
        recv_stall_pct = 75;
        run_random(145);

        // the other way round
        send_idle_pct  = 75;
        recv_stall_pct = 14;
        run_random(275);

        // flat out
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(405);

        @(negedge aclk);
        s_valid <= 1'b0;

        // drain, then keep watching so any digit with nothing due is caught
        while (sb.pending() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);

        $display("%0d numbers sent, %0d of them out of range and dropped",
                 sb.numbers_taken, sb.numbers_dropped);
        $display("%0d digits compared, %0d mismatches", sb.digits_checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
